// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define ASSERT_STD(lbl, prop, msg) \
   `ASSERT_AT(lbl, clock, reset, prop, msg)

`endif

// ----- hdl/sasc_pkg.sv -----
// ----------------------------------------------------------------------------
// sasc_pkg
// Types and constants of the set-associative score cache.
// ----------------------------------------------------------------------------
`default_nettype none

package sasc_pkg;

   localparam int SETS     = 1024;
   localparam int WAYS     = 4;
   localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int KEY_W    = 64;
   localparam int SCORE_W  = 32;
   localparam int COUNT_W  = 13;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic               REG_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      MODE_PROBE = 2'd0,
      MODE_STORE = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      mode_type                  mode;
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score_in;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [SCORE_W-1:0] score_out;
      logic [COUNT_W-1:0]        occupied_count;
   } rsp_type;

   typedef struct packed {
      logic [WAYS-1:0]                 valid;
      logic [WAYS-1:0][KEY_W-1:0]      key;
      logic [WAYS-1:0][SCORE_W-1:0]    score;
   } row_type;

   typedef struct packed {
      logic                we;
      logic [SET_BITS-1:0] addr;
      row_type             data;
   } ram_wr_type;

   typedef struct packed {
      logic                hit;
      logic [WAY_BITS-1:0] hit_way;
      logic                empty;
      logic [WAY_BITS-1:0] empty_way;
   } lookup_type;

endpackage

`default_nettype wire

// ----- hdl/set_assoc_score_cache.sv -----
// ----------------------------------------------------------------------------
// set_assoc_score_cache
// Four-way set-associative cache from 64-bit key to signed 32-bit score.
// ----------------------------------------------------------------------------
// A probe or store is taken when start is high and busy is low. The set row
// is read from the row memory, then compared and, for a store, written back;
// the result is strobed on rsp_strobe, and the next transaction can be taken
// in that same cycle. The strobe is shown for exactly one cycle, while
// rsp_data keeps the result until the next one; the receiver must take it.
// A clear strobes its result in the cycle after it is taken, then busy stays
// high while every set row is invalidated, one per cycle. The same pass runs,
// from the first row, after reset and after every write of the enable
// register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module set_assoc_score_cache
   import sasc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire req_type            req_data,
   output      logic               rsp_strobe,
   output      rsp_type            rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output      logic [PDATA_W-1:0] prdata,
   output      logic               pready
);

   state_type           state_ff, state_in;
   logic [SET_BITS-1:0] sweep_idx_ff, sweep_idx_in;
   logic [COUNT_W-1:0]  occupied_ff, occupied_in;
   logic [WAY_BITS-1:0] cursor_ff, cursor_in;
   logic                enable_ff, enable_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   req_type             req_ff, req_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                cfg_write;
   logic                rd_en;
   row_type             rd_row;
   row_type             new_row;
   ram_wr_type          wr;
   lookup_type          lookup;
   logic [WAY_BITS-1:0] way;

   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[PADDR_W-1:2] == REG_ENABLE) ?
                      {{(PDATA_W-1){1'b0}}, enable_ff} : '0;

   sasc_row_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_data.key[SET_BITS-1:0]),
      .rd_data (rd_row),
      .wr      (wr)
   );

   sasc_way_match u_match (
      .row    (rd_row),
      .key    (req_ff.key),
      .result (lookup)
   );

   always_comb begin
      state_in      = state_ff;
      sweep_idx_in  = sweep_idx_ff;
      occupied_in   = occupied_ff;
      cursor_in     = cursor_ff;
      enable_in     = enable_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      way           = cursor_ff;
      new_row       = rd_row;
      wr.we         = 1'b0;
      wr.addr       = sweep_idx_ff;
      wr.data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.mode == MODE_CLEAR) begin
                  occupied_in   = '0;
                  cursor_in     = '0;
                  sweep_idx_in  = '0;
                  state_in      = ST_SWEEP;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (req_ff.mode)
               MODE_PROBE: begin
                  if (enable_ff && lookup.hit) begin
                     rsp_in.hit       = 1'b1;
                     rsp_in.score_out = rd_row.score[lookup.hit_way];
                  end
               end
               MODE_STORE: begin
                  if (enable_ff) begin
                     priority if (lookup.hit) begin
                        way = lookup.hit_way;
                     end else if (lookup.empty) begin
                        way = lookup.empty_way;
                        if (occupied_ff != COUNT_MAX) begin
                           occupied_in = occupied_ff + COUNT_W'(1);
                        end
                     end else begin
                        way       = cursor_ff;
                        cursor_in = cursor_ff + WAY_BITS'(1);
                     end
                     new_row.valid[way] = 1'b1;
                     new_row.key[way]   = req_ff.key;
                     new_row.score[way] = req_ff.score_in;
                     wr.we              = 1'b1;
                     wr.addr            = req_ff.key[SET_BITS-1:0];
                     wr.data            = new_row;
                  end
               end
               MODE_CLEAR, MODE_NOP: begin
               end
            endcase
            rsp_in.occupied_count = occupied_in;
         end
         ST_SWEEP: begin
            wr.we = 1'b1;
            if (sweep_idx_ff == SET_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_idx_in = sweep_idx_ff + SET_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_write && (paddr[PADDR_W-1:2] == REG_ENABLE)) begin
         enable_in    = pwdata[0];
         occupied_in  = '0;
         cursor_in    = '0;
         sweep_idx_in = '0;
         state_in     = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_idx_ff  <= '0;
         occupied_ff   <= '0;
         cursor_ff     <= '0;
         enable_ff     <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_idx_ff  <= sweep_idx_in;
         occupied_ff   <= occupied_in;
         cursor_ff     <= cursor_in;
         enable_ff     <= enable_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_STD(a_rsp_source, rsp_strobe_ff |-> ($past(state_ff) == ST_LOOKUP || ($past(state_ff) == ST_IDLE && $past(req_data.mode) == MODE_CLEAR)), "result strobe without a transaction")
   `ASSERT_STD(a_sweep_zeroed, (state_ff == ST_SWEEP) |-> (occupied_ff == '0 && cursor_ff == '0), "count or cursor nonzero during sweep")
   `ASSERT_STD(a_count_step, (occupied_ff != $past(occupied_ff)) |-> (occupied_ff == '0 || ($past(state_ff) == ST_LOOKUP && occupied_ff == $past(occupied_ff) + COUNT_W'(1))), "occupied count moved unexpectedly")

endmodule

`default_nettype wire

// ----- hdl/sasc_row_ram.sv -----
// ----------------------------------------------------------------------------
// sasc_row_ram
// One row per set: valid bits, keys and scores of all ways. Registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sasc_row_ram
   import sasc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [SET_BITS-1:0] rd_addr,
   output      row_type             rd_data,
   input  wire ram_wr_type          wr
);

   row_type mem [SETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/sasc_way_match.sv -----
// ----------------------------------------------------------------------------
// sasc_way_match
// Tag compare over the ways of one set; finds the matching and first empty way.
// ----------------------------------------------------------------------------
`default_nettype none

module sasc_way_match
   import sasc_pkg::*;
(
   input  wire row_type          row,
   input  wire logic [KEY_W-1:0] key,
   output      lookup_type       result
);

   always_comb begin
      result = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row.valid[w] && (row.key[w] == key)) begin
            result.hit     = 1'b1;
            result.hit_way = WAY_BITS'(w);
         end
         if (!row.valid[w]) begin
            result.empty     = 1'b1;
            result.empty_way = WAY_BITS'(w);
         end
      end
   end

endmodule

`default_nettype wire
